// ===== hw/rtl/clnwd_pkg.sv =====
`default_nettype none

package clnwd_pkg;

  // One input transaction.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  byte_value;
    logic [7:0]  position;
    logic [15:0] number;
  } clnwd_in_t;

  // One port write.
  typedef struct packed {
    logic [7:0] port_value;
    logic       last_of_run;
  } clnwd_out_t;

  // Opcodes.
  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_NUM  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Port byte forming.
  localparam logic [7:0] LOW_KEEP    = 8'h0f;
  localparam logic [7:0] NIBBLE_MASK = 8'hf4;
  localparam logic [7:0] LATCH_VALUE = 8'h00;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  // Division by ten as (n * RECIP) >> RECIP_SHIFT, exact for all 16-bit n.
  localparam logic [15:0] RECIP       = 16'hcccd;
  localparam int          RECIP_SHIFT = 19;

  // Microcode fields.
  typedef enum logic [1:0] {
    EM_NONE,
    EM_HI,
    EM_LATCH,
    EM_LO
  } emit_t;

  typedef enum logic [1:0] {
    NX_STEP,      // go to the following step
    NX_BYTE_END,  // byte done: finish, or fetch the next digit
    NX_WAIT       // hold until the conversion is finished
  } nxt_t;

  typedef struct packed {
    emit_t emit;
    logic  div;
    nxt_t  nxt;
  } uword_t;

  localparam logic [2:0] STEP_HI     = 3'd0;
  localparam logic [2:0] STEP_LATCH1 = 3'd1;
  localparam logic [2:0] STEP_LO     = 3'd2;
  localparam logic [2:0] STEP_LATCH2 = 3'd3;
  localparam logic [2:0] STEP_WAIT   = 3'd4;

  // Control store.
  function automatic uword_t ucode(input logic [2:0] step);
    uword_t w;
    case (step)
      STEP_HI:     w = '{emit: EM_HI,    div: 1'b1, nxt: NX_STEP};
      STEP_LATCH1: w = '{emit: EM_LATCH, div: 1'b1, nxt: NX_STEP};
      STEP_LO:     w = '{emit: EM_LO,    div: 1'b1, nxt: NX_STEP};
      STEP_LATCH2: w = '{emit: EM_LATCH, div: 1'b1, nxt: NX_BYTE_END};
      STEP_WAIT:   w = '{emit: EM_NONE,  div: 1'b1, nxt: NX_WAIT};
      default:     w = '{emit: EM_NONE,  div: 1'b1, nxt: NX_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_writer_decimal_core.sv =====
`default_nettype none

// Character LCD writer for a 4-bit display port. A transaction is taken when
// start is high and busy is low; it asks for a command byte (opcode 0), a data
// byte (opcode 1) or an unsigned number shown in decimal after a set-address
// command (opcode 2); opcode 3 is taken and does nothing. Every byte leaves as
// four port writes, one per cycle on out_valid: high nibble with enable, a zero
// latch write, low nibble with enable, another zero. The receiver cannot stall:
// each write is present for exactly one cycle and last_of_run marks the final
// write of a transaction. Busy stays high for the whole transaction and falls as
// its final write is presented. A number sends the address byte and then one
// byte per digit; when it has more than three digits, the sequencer waits after
// the address byte until the divide-by-ten step, which produces one digit per
// cycle while the address writes go out, has made every digit.
module char_lcd_nibble_writer_decimal_core #(
  parameter int MAX_DIGITS = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire clnwd_pkg::clnwd_in_t   in_item,
  output logic                        out_valid,
  output clnwd_pkg::clnwd_out_t       out_item
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // Sequencer control state.
  logic                      run_r, run_nxt;
  logic [2:0]                pc_r, pc_nxt;
  logic                      conv_busy_r, conv_busy_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [15:0]               num_r, num_nxt;
  logic [7:0]                cur_r, cur_nxt;
  logic                      data_r, data_nxt;
  logic [3:0]                dig_r [MAX_DIGITS];
  logic [3:0]                dig_nxt [MAX_DIGITS];
  clnwd_pkg::clnwd_out_t     out_r, out_nxt;

  clnwd_pkg::uword_t         uw;
  logic                      div_en;
  logic                      pending;
  logic [31:0]               prod;
  logic [15:0]               quo;
  logic [15:0]               rem;
  logic [7:0]                mask;

  // Divide-by-ten unit: the quotient comes from a reciprocal multiply and the
  // remainder, always below ten, from one subtraction.
  assign prod = 32'(num_r) * 32'(clnwd_pkg::RECIP);
  assign quo  = 16'(prod >> clnwd_pkg::RECIP_SHIFT);
  assign rem  = num_r - ((quo << 3) + (quo << 1));

  assign uw      = clnwd_pkg::ucode(pc_r);
  assign div_en  = run_r && uw.div && conv_busy_r;
  assign pending = (cnt_r != '0);
  assign mask    = clnwd_pkg::NIBBLE_MASK | {7'd0, data_r};

  always_comb begin
    run_nxt       = run_r;
    pc_nxt        = pc_r;
    conv_busy_nxt = conv_busy_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    cur_nxt       = cur_r;
    data_nxt      = data_r;
    dig_nxt       = dig_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (!run_r) begin
      if (start && (in_item.opcode != clnwd_pkg::OP_NONE)) begin
        run_nxt       = 1'b1;
        pc_nxt        = clnwd_pkg::STEP_HI;
        num_nxt       = in_item.number;
        cnt_nxt       = '0;
        conv_busy_nxt = (in_item.opcode == clnwd_pkg::OP_NUM);
        data_nxt      = (in_item.opcode == clnwd_pkg::OP_DATA);
        cur_nxt       = (in_item.opcode == clnwd_pkg::OP_NUM) ? in_item.position
                                                              : in_item.byte_value;
      end
    end else begin
      // Digits are pushed least significant first onto a stack whose top is
      // entry zero, so they pop out most significant first.
      if (div_en) begin
        dig_nxt[0] = rem[3:0];
        for (int i = 1; i < MAX_DIGITS; i++) begin
          dig_nxt[i] = dig_r[i-1];
        end
        num_nxt       = quo;
        cnt_nxt       = cnt_r + 1'b1;
        conv_busy_nxt = (quo != 16'd0) &&
                        ((CNT_W+1)'(cnt_r) + 1'b1 < (CNT_W+1)'(MAX_DIGITS));
      end

      out_nxt.last_of_run = 1'b0;
      case (uw.emit)
        clnwd_pkg::EM_HI: begin
          out_valid_nxt      = 1'b1;
          out_nxt.port_value = (cur_r | clnwd_pkg::LOW_KEEP) & mask;
        end
        clnwd_pkg::EM_LATCH: begin
          out_valid_nxt      = 1'b1;
          out_nxt.port_value = clnwd_pkg::LATCH_VALUE;
        end
        clnwd_pkg::EM_LO: begin
          out_valid_nxt      = 1'b1;
          out_nxt.port_value = ({cur_r[3:0], 4'h0} | clnwd_pkg::LOW_KEEP) & mask;
        end
        default: begin
        end
      endcase

      case (uw.nxt)
        clnwd_pkg::NX_STEP: begin
          pc_nxt = pc_r + 3'd1;
        end
        clnwd_pkg::NX_BYTE_END: begin
          if (!pending) begin
            run_nxt             = 1'b0;
            out_nxt.last_of_run = 1'b1;
          end else if (conv_busy_r) begin
            pc_nxt = clnwd_pkg::STEP_WAIT;
          end else begin
            pc_nxt = clnwd_pkg::STEP_HI;
          end
        end
        clnwd_pkg::NX_WAIT: begin
          if (!conv_busy_r) begin
            pc_nxt = clnwd_pkg::STEP_HI;
          end
        end
        default: begin
          pc_nxt = clnwd_pkg::STEP_WAIT;
        end
      endcase

      // Pop the next digit whenever the sequencer returns to the first step.
      if (pending && !conv_busy_r &&
          ((uw.nxt == clnwd_pkg::NX_BYTE_END) || (uw.nxt == clnwd_pkg::NX_WAIT))) begin
        cur_nxt  = clnwd_pkg::ASCII_ZERO | {4'd0, dig_r[0]};
        data_nxt = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          dig_nxt[i] = dig_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      pc_r        <= clnwd_pkg::STEP_HI;
      conv_busy_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      pc_r        <= pc_nxt;
      conv_busy_r <= conv_busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r  <= num_nxt;
    cur_r  <= cur_nxt;
    data_r <= data_nxt;
    dig_r  <= dig_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = run_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // The final write of a transaction leaves the block idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_of_run |-> !busy)
    else $error("last write issued while still busy");

  // Every real transaction starts the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.opcode != clnwd_pkg::OP_NONE) |=> busy)
    else $error("accepted transaction did not start the sequencer");

  // The digit stack never holds more than its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(cnt_r) <= (CNT_W+1)'(MAX_DIGITS))
    else $error("digit count overflow");

  // Writes only follow cycles in which the sequencer was running.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("port write without a running sequence");

endmodule

`default_nettype wire
